// ===== hw/rtl/kmr_pkg.sv =====
// Shared types and constants for the k-mer set read matcher.
// No dependencies; imported by every module under hw/rtl.
package kmr_pkg;

   localparam int KMER_LEN_DEF     = 31;
   localparam int TABLE_SLOTS_DEF  = 8192;   // power of two
   localparam int MAX_READ_LEN_DEF = 512;
   localparam int PROBE_LIMIT_DEF  = 8;
   localparam int QUEUE_DEPTH      = 4;

   localparam int KEY_MAX_W  = 64;
   localparam int KMER_IN_W  = 62;
   localparam int HITS_W     = 10;
   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 16;

   localparam logic [31:0] HASH_MUL_LO = 32'h7F4A_7C15;
   localparam logic [31:0] HASH_MUL_HI = 32'h9E37_79B9;

   localparam logic [3:0] BAM_A = 4'h1;
   localparam logic [3:0] BAM_C = 4'h2;
   localparam logic [3:0] BAM_G = 4'h4;
   localparam logic [3:0] BAM_T = 4'h8;

   typedef enum logic [1:0] {
      MODE_LOAD  = 2'd0,
      MODE_BASE  = 2'd1,
      MODE_CLEAR = 2'd2,
      MODE_NONE  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STS_INSERTED  = 2'd0,
      STS_PRESENT   = 2'd1,
      STS_FULL      = 2'd2,
      STS_READ_DONE = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_LOOKUP = 2'd1,
      OP_FINISH = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef struct packed {
      op_type                 op;
      logic                   last;
      logic [KEY_MAX_W-1:0]   fwd;
      logic [KEY_MAX_W-1:0]   rev;
   } op_entry_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_MUL0,
      S_MUL1,
      S_MUL2,
      S_HASH,
      S_READ,
      S_CMP,
      S_EMIT
   } back_state_type;

endpackage

// ===== hw/rtl/kmr_queue.sv =====
// Small register queue of operations between front and back ends.
// Depends on kmr_pkg.
module kmr_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  kmr_pkg::op_entry_type push_data,
   output logic                  full,
   input  logic                  pop,
   output kmr_pkg::op_entry_type pop_data,
   output logic                  empty
);
   import kmr_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   op_entry_type       slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]     count_ff, count_in;

   assign full     = (count_ff == (PTR_W+1)'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hw/rtl/kmr_front.sv =====
// Front end: accepts request transactions, keeps the rolling base window
// and issues table operations. Depends on kmr_pkg.
module kmr_front #(
   parameter int KMER_LEN = kmr_pkg::KMER_LEN_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [kmr_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic [1:0]                        req_tuser,
   input  logic                              req_tlast,
   input  logic                              q_full,
   input  logic                              clearing,
   output logic                              push,
   output kmr_pkg::op_entry_type             push_data
);
   import kmr_pkg::*;

   localparam int KEY_W = 2 * KMER_LEN;
   localparam int RUN_W = $clog2(KMER_LEN + 1);

   logic [KEY_W-1:0]     window_ff, window_in;
   logic [RUN_W-1:0]     run_ff, run_in;
   logic                 accept;
   logic [KMER_IN_W-1:0] kmer_code;
   logic [3:0]           base_code;
   mode_type             mode;
   logic [KEY_W-1:0]     fwd, rev, shifted;
   logic                 base_ok;
   logic [1:0]           base_val;
   logic                 full_win;

   assign kmer_code  = req_tdata[KMER_IN_W-1:0];
   assign base_code  = req_tdata[KMER_IN_W+3:KMER_IN_W];
   assign mode       = mode_type'(req_tuser);
   assign req_tready = !q_full && !clearing;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      fwd = KEY_W'(kmer_code);
      for (int i = 0; i < KMER_LEN; i++) begin
         rev[2*(KMER_LEN-1-i) +: 2] = ~fwd[2*i +: 2];
      end
   end

   always_comb begin
      base_ok  = 1'b1;
      base_val = 2'd0;
      case (base_code)
         BAM_A:   base_val = 2'd0;
         BAM_C:   base_val = 2'd1;
         BAM_G:   base_val = 2'd2;
         BAM_T:   base_val = 2'd3;
         default: base_ok  = 1'b0;
      endcase
   end

   always_comb begin
      shifted   = {window_ff[KEY_W-3:0], base_val};
      window_in = window_ff;
      run_in    = run_ff;
      full_win  = 1'b0;
      push      = 1'b0;
      push_data.op   = OP_INSERT;
      push_data.last = req_tlast;
      push_data.fwd  = KEY_MAX_W'(fwd);
      push_data.rev  = KEY_MAX_W'(rev);
      if (accept) begin
         case (mode)
            MODE_LOAD: begin
               push = 1'b1;
            end
            MODE_BASE: begin
               if (base_ok) begin
                  window_in = shifted;
                  if (run_ff < RUN_W'(KMER_LEN)) begin
                     run_in = run_ff + 1'b1;
                  end
                  full_win = (run_in == RUN_W'(KMER_LEN));
               end else begin
                  window_in = {window_ff[KEY_W-3:0], 2'b00};
                  run_in    = '0;
               end
               push_data.fwd = KEY_MAX_W'(window_in);
               push_data.op  = full_win ? OP_LOOKUP : OP_FINISH;
               push          = full_win || req_tlast;
               if (req_tlast) begin
                  window_in = '0;
                  run_in    = '0;
               end
            end
            MODE_CLEAR: begin
               push_data.op = OP_CLEAR;
               push         = 1'b1;
            end
            default: begin
               push = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
         run_ff    <= '0;
      end else begin
         window_ff <= window_in;
         run_ff    <= run_in;
      end
   end

endmodule

// ===== hw/rtl/kmr_back.sv =====
// Back end: hashes keys, probes the k-mer table, counts hits and drives the
// response register. Holds the table memory. Depends on kmr_pkg.
module kmr_back #(
   parameter int KMER_LEN     = kmr_pkg::KMER_LEN_DEF,
   parameter int TABLE_SLOTS  = kmr_pkg::TABLE_SLOTS_DEF,
   parameter int MAX_READ_LEN = kmr_pkg::MAX_READ_LEN_DEF,
   parameter int PROBE_LIMIT  = kmr_pkg::PROBE_LIMIT_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              q_empty,
   input  kmr_pkg::op_entry_type             pop_data,
   output logic                              pop,
   output logic                              clearing,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [kmr_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic [1:0]                        rsp_tuser
);
   import kmr_pkg::*;

   localparam int KEY_W  = 2 * KMER_LEN;
   localparam int SLOT_W = $clog2(TABLE_SLOTS);
   localparam int PRB_W  = $clog2(PROBE_LIMIT + 1);
   localparam int HIT_CAP = (MAX_READ_LEN < 1023) ? MAX_READ_LEN : 1023;

   logic [KEY_W:0]       table_mem [TABLE_SLOTS];
   logic [KEY_W:0]       rd_data_ff;
   logic                 mem_we;
   logic [SLOT_W-1:0]    mem_waddr;
   logic [KEY_W:0]       mem_wdata;

   back_state_type       state_ff, state_in;
   op_entry_type         entry_ff, entry_in;
   logic [KEY_MAX_W-1:0] key_ff, key_in;
   logic [63:0]          prod_ff, prod_in;
   logic [31:0]          cross_ff, cross_in;
   logic [SLOT_W-1:0]    slot_ff, slot_in;
   logic [PRB_W-1:0]     probe_ff, probe_in;
   logic                 phase_ff, phase_in;
   logic                 ins_new_ff, ins_new_in;
   status_type           res_ff, res_in;
   logic [HITS_W-1:0]    hit_ff, hit_in;
   logic [SLOT_W-1:0]    clr_idx_ff, clr_idx_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic [HITS_W-1:0]    rsp_hits_ff, rsp_hits_in;

   logic [63:0]          h_sum, h_mix;
   logic                 slot_v, slot_match, probe_end;
   status_type           outcome;
   logic [SLOT_W-1:0]    slot_next;

   assign clearing   = (state_ff == S_CLEAR);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = RSP_DATA_W'({(rsp_hits_ff != '0), rsp_hits_ff});

   assign h_sum      = prod_ff + {cross_ff, 32'h0};
   assign h_mix      = h_sum ^ (h_sum >> 29);
   assign slot_v     = rd_data_ff[KEY_W];
   assign slot_match = (rd_data_ff[KEY_W-1:0] == key_ff[KEY_W-1:0]);
   assign probe_end  = (probe_ff == PRB_W'(PROBE_LIMIT - 1));
   assign slot_next  = (slot_ff == SLOT_W'(TABLE_SLOTS - 1)) ? '0 : slot_ff + 1'b1;

   always_comb begin
      state_in      = state_ff;
      entry_in      = entry_ff;
      key_in        = key_ff;
      prod_in       = prod_ff;
      cross_in      = cross_ff;
      slot_in       = slot_ff;
      probe_in      = probe_ff;
      phase_in      = phase_ff;
      ins_new_in    = ins_new_ff;
      res_in        = res_ff;
      hit_in        = hit_ff;
      clr_idx_in    = clr_idx_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_hits_in   = rsp_hits_ff;
      pop           = 1'b0;
      mem_we        = 1'b0;
      mem_waddr     = slot_ff;
      mem_wdata     = {1'b1, key_ff[KEY_W-1:0]};
      outcome       = STS_FULL;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_CLEAR: begin
            mem_we     = 1'b1;
            mem_waddr  = clr_idx_ff;
            mem_wdata  = '0;
            clr_idx_in = clr_idx_ff + 1'b1;
            if (clr_idx_ff == SLOT_W'(TABLE_SLOTS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (!q_empty) begin
               pop        = 1'b1;
               entry_in   = pop_data;
               key_in     = pop_data.fwd;
               phase_in   = 1'b0;
               ins_new_in = 1'b0;
               case (pop_data.op)
                  OP_CLEAR: begin
                     clr_idx_in = '0;
                     state_in   = S_CLEAR;
                  end
                  OP_FINISH: state_in = S_EMIT;
                  default:   state_in = S_MUL0;
               endcase
            end
         end
         S_MUL0: begin
            prod_in  = key_ff[31:0] * HASH_MUL_LO;
            state_in = S_MUL1;
         end
         S_MUL1: begin
            cross_in = 32'(key_ff[63:32] * HASH_MUL_LO);
            state_in = S_MUL2;
         end
         S_MUL2: begin
            cross_in = cross_ff + 32'(key_ff[31:0] * HASH_MUL_HI);
            state_in = S_HASH;
         end
         S_HASH: begin
            slot_in  = h_mix[SLOT_W-1:0];
            probe_in = '0;
            state_in = S_READ;
         end
         S_READ: begin
            state_in = S_CMP;
         end
         S_CMP: begin
            if (entry_ff.op == OP_INSERT) begin
               if (!slot_v) begin
                  mem_we  = 1'b1;
                  outcome = STS_INSERTED;
               end else if (slot_match) begin
                  outcome = STS_PRESENT;
               end else if (probe_end) begin
                  outcome = STS_FULL;
               end else begin
                  slot_in  = slot_next;
                  probe_in = probe_ff + 1'b1;
                  state_in = S_READ;
               end
               if (slot_match || !slot_v || probe_end) begin
                  if (outcome == STS_FULL) begin
                     res_in   = STS_FULL;
                     state_in = S_EMIT;
                  end else if (!phase_ff) begin
                     ins_new_in = (outcome == STS_INSERTED);
                     phase_in   = 1'b1;
                     key_in     = entry_ff.rev;
                     state_in   = S_MUL0;
                  end else begin
                     res_in   = (ins_new_ff || outcome == STS_INSERTED) ?
                                STS_INSERTED : STS_PRESENT;
                     state_in = S_EMIT;
                  end
               end
            end else begin
               if (slot_v && !slot_match && !probe_end) begin
                  slot_in  = slot_next;
                  probe_in = probe_ff + 1'b1;
                  state_in = S_READ;
               end else begin
                  if (slot_v && slot_match && hit_ff < HITS_W'(HIT_CAP)) begin
                     hit_in = hit_ff + 1'b1;
                  end
                  state_in = entry_ff.last ? S_EMIT : S_IDLE;
               end
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               if (entry_ff.op == OP_INSERT) begin
                  rsp_status_in = res_ff;
                  rsp_hits_in   = '0;
               end else begin
                  rsp_status_in = STS_READ_DONE;
                  rsp_hits_in   = hit_ff;
                  hit_in        = '0;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_idx_ff   <= '0;
         hit_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_idx_ff   <= clr_idx_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff      <= entry_in;
      key_ff        <= key_in;
      prod_ff       <= prod_in;
      cross_ff      <= cross_in;
      slot_ff       <= slot_in;
      probe_ff      <= probe_in;
      phase_ff      <= phase_in;
      ins_new_ff    <= ins_new_in;
      res_ff        <= res_in;
      rsp_status_ff <= rsp_status_in;
      rsp_hits_ff   <= rsp_hits_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= table_mem[slot_ff];
   end

endmodule

// ===== hw/rtl/kmer_set_read_matcher_top.sv =====
// Top level of the k-mer set read matcher: front end, operation queue and
// back end. Depends on kmr_pkg, kmr_front, kmr_queue and kmr_back.
//
//   channel  direction  fields
//   req_*    in         tuser=mode, tdata=kmer_code/base_code, tlast=last_base
//   rsp_*    out        tuser=status, tdata=read_hits/read_matched
//
// A window lookup runs S_MUL0-2, S_HASH, S_READ and S_CMP, repeating S_READ
// and S_CMP per extra probe; a load does so for the forward and reverse key,
// bounded by the 32x32 hash multiplies and the single table read port. Bases
// without a full window push nothing unless last_base is set. After reset and
// after a clear transaction the table is swept slot by slot with req_tready
// low. The response register lets the back end run on while a result waits.
module kmer_set_read_matcher_top #(
   parameter int KMER_LEN     = kmr_pkg::KMER_LEN_DEF,
   parameter int TABLE_SLOTS  = kmr_pkg::TABLE_SLOTS_DEF,
   parameter int MAX_READ_LEN = kmr_pkg::MAX_READ_LEN_DEF,
   parameter int PROBE_LIMIT  = kmr_pkg::PROBE_LIMIT_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [kmr_pkg::REQ_DATA_W-1:0]    req_tdata,  // kmer_code[61:0], base_code[65:62]
   input  logic [1:0]                        req_tuser,  // mode[1:0]
   input  logic                              req_tlast,  // last_base
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [kmr_pkg::RSP_DATA_W-1:0]    rsp_tdata,  // read_hits[9:0], read_matched[10]
   output logic [1:0]                        rsp_tuser   // status[1:0]
);
   import kmr_pkg::*;

   op_entry_type push_data, pop_data;
   logic         push, pop, q_full, q_empty, clearing;

   kmr_front #(
      .KMER_LEN (KMER_LEN)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .clearing   (clearing),
      .push       (push),
      .push_data  (push_data)
   );

   kmr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (q_empty)
   );

   kmr_back #(
      .KMER_LEN     (KMER_LEN),
      .TABLE_SLOTS  (TABLE_SLOTS),
      .MAX_READ_LEN (MAX_READ_LEN),
      .PROBE_LIMIT  (PROBE_LIMIT)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .pop_data   (pop_data),
      .pop        (pop),
      .clearing   (clearing),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
